// ===== src/assert_macros.svh =====
// Assertion macros for the checker file.
// Self-contained; no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define TMWS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tmws assertion failed");

// Next-cycle implication, off during reset.
`define TMWS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tmws assertion failed");

`endif

// ===== src/tmws_pkg.sv =====
// Shared types, constants and command codes of the trap-model walk engine.
// No dependencies.
`default_nettype none

package tmws_pkg;

	localparam int GRID_DEPTH = 64;
	localparam int GRID_AW    = 6;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_LANE_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CUT_PLUS_X    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CUT_MINUS_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LATERAL_SHARE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_ALPHA     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DISORDER_SEED = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_POINTS   = 3'd6;

	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_STEP  = 2'd2;

	localparam logic [63:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] SM_MUL2  = 64'h94d049bb133111eb;
	localparam logic [63:0] SALT_X   = 64'h243f6a8885a308d3;
	localparam logic [63:0] SALT_Y   = 64'h13198a2e03707344;
	localparam logic [63:0] SALT_Z   = 64'ha4093822299f31d0;

	typedef logic [4:0] op_t;
	localparam op_t OP_NOP   = 5'd0;
	localparam op_t OP_LOAD  = 5'd1;
	localparam op_t OP_START = 5'd2;
	localparam op_t OP_BEGIN = 5'd3;
	localparam op_t OP_HINIT = 5'd4;
	localparam op_t OP_MULP  = 5'd5;
	localparam op_t OP_ULOAD = 5'd6;
	localparam op_t OP_NORM  = 5'd7;
	localparam op_t OP_SQR   = 5'd8;
	localparam op_t OP_LOGF  = 5'd9;
	localparam op_t OP_EMUL  = 5'd10;
	localparam op_t OP_EXPS  = 5'd11;
	localparam op_t OP_DWELL = 5'd12;
	localparam op_t OP_CMP   = 5'd13;
	localparam op_t OP_MOVE  = 5'd14;
	localparam op_t OP_MOD   = 5'd15;
	localparam op_t OP_WB    = 5'd16;
	localparam op_t OP_OUT   = 5'd17;
	localparam op_t OP_FIN   = 5'd18;

	typedef struct packed {
		op_t        op;
		logic [3:0] sel;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       done;
		logic       hit;
	} stat_t;

	function automatic logic [63:0] isqrt_f(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] rem;
		logic [63:0] bit_v;
		int i;
		res = '0;
		rem = v;
		bit_v = 64'h4000_0000_0000_0000;
		for (i = 0; i < 32; i++) begin
			if (rem >= res + bit_v) begin
				rem = rem - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	// entry k holds 2^(2^-(k+1)) in Q1.30
	function automatic logic [15:0][30:0] exp_tab_f();
		logic [15:0][30:0] t;
		logic [63:0] c;
		int k;
		c = 64'd2 << 30;
		for (k = 0; k < 16; k++) begin
			c = isqrt_f(c << 30);
			t[k] = c[30:0];
		end
		return t;
	endfunction

	localparam logic [15:0][30:0] EXP_C = exp_tab_f();

endpackage

`default_nettype wire

// ===== src/tmws_if.sv =====
// Valid/ready channel interfaces for the item input and the result output.
// No dependencies.
`default_nettype none

interface tmws_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [5:0]  grid_index;
	logic [63:0] grid_time;
	logic [52:0] rand_value;
	modport source (output valid, func, grid_index, grid_time, rand_value, input ready);
	modport sink (input valid, func, grid_index, grid_time, rand_value, output ready);
endinterface

interface tmws_out_if;
	logic              valid;
	logic              ready;
	logic signed [63:0] position_x;
	logic [7:0]        position_y;
	logic [7:0]        position_z;
	logic [5:0]        first_index;
	logic [6:0]        crossed_count;
	logic              finished;
	modport source (output valid, position_x, position_y, position_z, first_index,
		crossed_count, finished, input ready);
	modport sink (input valid, position_x, position_y, position_z, first_index,
		crossed_count, finished, output ready);
endinterface

`default_nettype wire

// ===== src/tmws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tmws_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== src/tmws_dp.sv =====
// Datapath: config registers, walker state, hash/log/exp unit around one
// shared 32x32 multiplier, grid memory and result register. Uses tmws_pkg, tmws_ram.
`default_nettype none

module tmws_dp import tmws_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output stat_t                stat,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [63:0]          cfg_data,
	input  logic                 in_take,
	input  logic [1:0]           func,
	input  logic [5:0]           grid_index,
	input  logic [63:0]          grid_time,
	input  logic [52:0]          rand_value,
	output logic signed [63:0]   position_x,
	output logic [7:0]           position_y,
	output logic [7:0]           position_z,
	output logic [5:0]           first_index,
	output logic [6:0]           crossed_count,
	output logic                 finished
);

	localparam logic [1:0] AX_NONE = 2'd0;
	localparam logic [1:0] AX_Y    = 2'd1;
	localparam logic [1:0] AX_Z    = 2'd2;

	// configuration
	logic [7:0]  lane_q;
	logic [53:0] cpx_q, cmx_q, ls_q;
	logic [23:0] ia_q;
	logic [63:0] seed_q;
	logic [6:0]  gp_q;

	// walker state
	logic [63:0] wx_q;
	logic [7:0]  wy_q, wz_q;
	logic [63:0] et_q;
	logic [6:0]  slot_q;

	// latched item
	logic [1:0]  func_q;
	logic [5:0]  gidx_q;
	logic [63:0] gtime_q;
	logic [52:0] rand_q;

	// working registers
	logic [63:0] h_q, v_q, plo_q, xd_q;
	logic [31:0] cr_q;
	logic [52:0] nm_q;
	logic [5:0]  nsh_q;
	logic [30:0] m_q;
	logic [15:0] frac_q;
	logic [21:0] l_q;
	logic [29:0] e_q;
	logic [30:0] r_q;
	logic [5:0]  first_q;
	logic [6:0]  cnt_q;
	logic [8:0]  tv_q;
	logic [1:0]  ax_q;

	// result register
	logic [63:0] ox_q;
	logic [7:0]  oy_q, oz_q;
	logic [5:0]  of_q;
	logic [6:0]  oc_q;
	logic        ofin_q;

	logic [6:0]  m_lim;
	logic [7:0]  w8;
	logic [63:0] gr_rd;
	logic        done, hit;
	logic [63:0] kc;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;

	assign m_lim = (gp_q > 7'(GRID_DEPTH)) ? 7'(GRID_DEPTH) : gp_q;
	assign w8    = (lane_q == 8'd0) ? 8'd1 : lane_q;
	assign done  = slot_q >= m_lim;
	assign hit   = !done && (et_q >= gr_rd);
	assign stat  = '{func: func_q, done: done, hit: hit};
	assign kc    = cmd.sel[2] ? SM_MUL2 : SM_MUL1;

	tmws_ram #(.WIDTH(64), .DEPTH(GRID_DEPTH)) u_grid (
		.clk   (clk),
		.we    (cmd.op == OP_LOAD && {1'b0, gidx_q} < 7'(GRID_DEPTH)),
		.waddr (gidx_q[GRID_AW-1:0]),
		.wdata (gtime_q),
		.raddr (slot_q[GRID_AW-1:0]),
		.rdata (gr_rd)
	);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MULP: begin
				case (cmd.sel[1:0])
					2'd0: begin mul_a = v_q[31:0];  mul_b = kc[31:0];  end
					2'd1: begin mul_a = v_q[63:32]; mul_b = kc[31:0];  end
					default: begin mul_a = v_q[31:0]; mul_b = kc[63:32]; end
				endcase
			end
			OP_SQR: begin
				mul_a = (cmd.sel == 4'd0) ? {1'b0, nm_q[52:22]} : {1'b0, m_q};
				mul_b = mul_a;
			end
			OP_EMUL: begin
				mul_a = {10'b0, l_q};
				mul_b = {8'b0, ia_q};
			end
			OP_EXPS: begin
				mul_a = {1'b0, r_q};
				mul_b = {1'b0, EXP_C[cmd.sel]};
			end
			default: ;
		endcase
	end

	assign prod = mul_a * mul_b;

	// hash combine, dwell and move helpers
	logic [63:0] hsrc, hsalt, hmix, nv;
	logic [31:0] sq_t;
	logic [13:0] e_int;
	logic [5:0]  sh6;
	logic [63:0] rr, dw;
	logic [64:0] esum;
	logic [55:0] r56, b56, ls56, t1, t2, t3;
	logic [16:0] wsh;

	always_comb begin
		unique case (cmd.sel[1:0])
			2'd0: begin hsrc = wx_q; hsalt = SALT_X; end
			2'd1: begin hsrc = {56'b0, wy_q}; hsalt = SALT_Y; end
			default: begin hsrc = {56'b0, wz_q}; hsalt = SALT_Z; end
		endcase
		hmix = (hsrc ^ hsalt) + SM_GAMMA;
		nv   = plo_q + {cr_q, 32'b0};
		sq_t = prod[61:30];
		e_int = e_q[29:16];
		sh6  = e_int[5:0] + 6'd4;
		rr   = {33'b0, r_q};
		if (e_int >= 14'd60) begin
			dw = '1;
		end else if (sh6 >= 6'd30) begin
			dw = rr << (sh6 - 6'd30);
		end else begin
			dw = rr >> (6'd30 - sh6);
		end
		esum = {1'b0, et_q} + {1'b0, dw};
		r56  = {3'b0, rand_q};
		b56  = {2'b0, cmx_q};
		ls56 = {2'b0, ls_q};
		t1   = b56 + ls56;
		t2   = b56 + {ls56[54:0], 1'b0};
		t3   = t1 + {ls56[54:0], 1'b0};
		wsh  = {9'b0, w8} << cmd.sel;
	end

	// control state: configuration and walker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q <= 8'd3;
			cpx_q  <= 54'd1508718000000000;
			cmx_q  <= 54'd3002424000000000;
			ls_q   <= 54'd1501193000000000;
			ia_q   <= 24'd218453;
			seed_q <= '0;
			gp_q   <= 7'd64;
			wx_q   <= '0;
			wy_q   <= '0;
			wz_q   <= '0;
			et_q   <= '0;
			slot_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_LANE_WIDTH:    lane_q <= cfg_data[7:0];
					CFG_CUT_PLUS_X:    cpx_q  <= cfg_data[53:0];
					CFG_CUT_MINUS_X:   cmx_q  <= cfg_data[53:0];
					CFG_LATERAL_SHARE: ls_q   <= cfg_data[53:0];
					CFG_INV_ALPHA:     ia_q   <= cfg_data[23:0];
					CFG_DISORDER_SEED: seed_q <= cfg_data;
					CFG_GRID_POINTS:   gp_q   <= cfg_data[6:0];
					default: ;
				endcase
			end
			case (cmd.op)
				OP_START: begin
					wx_q   <= '0;
					wy_q   <= '0;
					wz_q   <= '0;
					et_q   <= '0;
					slot_q <= '0;
				end
				OP_DWELL: et_q <= esum[64] ? '1 : esum[63:0];
				OP_CMP: if (hit) slot_q <= slot_q + 7'd1;
				OP_MOVE: begin
					if (r56 < {2'b0, cpx_q}) begin
						wx_q <= wx_q + 64'd1;
					end else if (r56 < b56) begin
						wx_q <= wx_q - 64'd1;
					end
				end
				OP_WB: begin
					if (ax_q == AX_Y) wy_q <= tv_q[7:0];
					if (ax_q == AX_Z) wz_q <= tv_q[7:0];
				end
				default: ;
			endcase
		end
	end

	// working and payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			func_q  <= func;
			gidx_q  <= grid_index;
			gtime_q <= grid_time;
			rand_q  <= rand_value;
		end
		case (cmd.op)
			OP_BEGIN: begin
				h_q     <= seed_q;
				xd_q    <= wx_q;
				first_q <= slot_q[5:0];
				cnt_q   <= '0;
			end
			OP_HINIT: v_q <= hmix ^ (hmix >> 30);
			OP_MULP: begin
				case (cmd.sel[1:0])
					2'd0: plo_q <= prod;
					2'd1: cr_q <= prod[31:0];
					2'd2: cr_q <= cr_q + prod[31:0];
					default: begin
						if (cmd.sel[2]) h_q <= h_q ^ nv ^ (nv >> 31);
						else v_q <= nv ^ (nv >> 27);
					end
				endcase
			end
			OP_ULOAD: begin
				nm_q   <= (h_q[63:11] < 53'd2) ? 53'd2 : h_q[63:11];
				nsh_q  <= '0;
				frac_q <= '0;
			end
			OP_NORM: begin
				// binary search for the leading one, largest step first
				case (cmd.sel)
					4'd0: if (nm_q[52:21] == '0) begin nm_q <= nm_q << 32; nsh_q <= nsh_q + 6'd32; end
					4'd1: if (nm_q[52:37] == '0) begin nm_q <= nm_q << 16; nsh_q <= nsh_q + 6'd16; end
					4'd2: if (nm_q[52:45] == '0) begin nm_q <= nm_q << 8; nsh_q <= nsh_q + 6'd8; end
					4'd3: if (nm_q[52:49] == '0) begin nm_q <= nm_q << 4; nsh_q <= nsh_q + 6'd4; end
					4'd4: if (nm_q[52:51] == '0) begin nm_q <= nm_q << 2; nsh_q <= nsh_q + 6'd2; end
					default: if (!nm_q[52]) begin nm_q <= nm_q << 1; nsh_q <= nsh_q + 6'd1; end
				endcase
			end
			OP_SQR: begin
				frac_q <= {frac_q[14:0], sq_t[31]};
				m_q    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
			end
			OP_LOGF: l_q <= {nsh_q + 6'd1, 16'b0} - {6'b0, frac_q};
			OP_EMUL: begin
				e_q <= prod[45:16];
				r_q <= 31'h4000_0000;
			end
			OP_EXPS: if (e_q[4'd15 - cmd.sel]) r_q <= prod[60:30];
			OP_CMP: if (hit) cnt_q <= cnt_q + 7'd1;
			OP_MOVE: begin
				ax_q <= AX_NONE;
				// lateral bands only when neither x band took the item
				if (r56 >= b56 && r56 >= {2'b0, cpx_q}) begin
					if (r56 < t1) begin
						tv_q <= {1'b0, wy_q} + 9'd1;
						ax_q <= AX_Y;
					end else if (r56 < t2) begin
						tv_q <= {1'b0, wy_q} + {1'b0, w8} - 9'd1;
						ax_q <= AX_Y;
					end else if (r56 < t3) begin
						tv_q <= {1'b0, wz_q} + 9'd1;
						ax_q <= AX_Z;
					end else begin
						tv_q <= {1'b0, wz_q} + {1'b0, w8} - 9'd1;
						ax_q <= AX_Z;
					end
				end
			end
			OP_MOD: if ({8'b0, tv_q} >= wsh) tv_q <= tv_q - wsh[8:0];
			OP_OUT: begin
				ox_q   <= xd_q;
				oy_q   <= wy_q;
				oz_q   <= wz_q;
				of_q   <= (cnt_q == 7'd0) ? 6'd0 : first_q;
				oc_q   <= cnt_q;
				ofin_q <= done;
			end
			OP_FIN: begin
				ox_q   <= wx_q;
				oy_q   <= wy_q;
				oz_q   <= wz_q;
				of_q   <= '0;
				oc_q   <= '0;
				ofin_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign position_x    = ox_q;
	assign position_y    = oy_q;
	assign position_z    = oz_q;
	assign first_index   = of_q;
	assign crossed_count = oc_q;
	assign finished      = ofin_q;

endmodule

`default_nettype wire

// ===== src/tmws_ctrl.sv =====
// Controller: sequences datapath commands for load, start and step items and
// owns the input ready and result valid. Uses tmws_pkg.
`default_nettype none

module tmws_ctrl import tmws_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_DISP  = 5'd1;
	localparam logic [4:0] S_HASH  = 5'd2;
	localparam logic [4:0] S_ULD   = 5'd3;
	localparam logic [4:0] S_NORM  = 5'd4;
	localparam logic [4:0] S_SQR   = 5'd5;
	localparam logic [4:0] S_LOG   = 5'd6;
	localparam logic [4:0] S_EMUL  = 5'd7;
	localparam logic [4:0] S_EXP   = 5'd8;
	localparam logic [4:0] S_DWELL = 5'd9;
	localparam logic [4:0] S_RD    = 5'd10;
	localparam logic [4:0] S_CMP   = 5'd11;
	localparam logic [4:0] S_MOVE  = 5'd12;
	localparam logic [4:0] S_MOD   = 5'd13;
	localparam logic [4:0] S_WB    = 5'd14;
	localparam logic [4:0] S_OUT   = 5'd15;
	localparam logic [4:0] S_FIN   = 5'd16;

	logic [4:0] state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic [1:0] crd_q, crd_d;
	logic       ov_q;
	logic       can_out, issue;
	logic [3:0] cm1;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = ov_q;
	assign can_out   = !ov_q || out_ready;
	assign cm1       = cnt_q - 4'd1;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		crd_d   = crd_q;
		cmd     = '{op: OP_NOP, sel: 4'd0};
		issue   = 1'b0;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_DISP;
			S_DISP: begin
				state_d = S_IDLE;
				case (stat.func)
					FUNC_LOAD:  cmd.op = OP_LOAD;
					FUNC_START: cmd.op = OP_START;
					FUNC_STEP: begin
						if (stat.done) begin
							state_d = S_FIN;
						end else begin
							cmd.op  = OP_BEGIN;
							state_d = S_HASH;
							cnt_d   = '0;
							crd_d   = '0;
						end
					end
					default: ;
				endcase
			end
			S_HASH: begin
				// per coordinate: init, then two 64-bit products in four parts each
				if (cnt_q == 4'd0) begin
					cmd = '{op: OP_HINIT, sel: {2'b0, crd_q}};
				end else begin
					cmd = '{op: OP_MULP, sel: {1'b0, cnt_q > 4'd4, cm1[1:0]}};
				end
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == 4'd8) begin
					cnt_d = '0;
					crd_d = crd_q + 2'd1;
					if (crd_q == 2'd2) state_d = S_ULD;
				end
			end
			S_ULD: begin
				cmd.op  = OP_ULOAD;
				state_d = S_NORM;
				cnt_d   = '0;
			end
			S_NORM: begin
				cmd   = '{op: OP_NORM, sel: cnt_q};
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == 4'd5) begin
					cnt_d   = '0;
					state_d = S_SQR;
				end
			end
			S_SQR: begin
				cmd   = '{op: OP_SQR, sel: cnt_q};
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == 4'd15) state_d = S_LOG;
			end
			S_LOG: begin
				cmd.op  = OP_LOGF;
				state_d = S_EMUL;
			end
			S_EMUL: begin
				cmd.op  = OP_EMUL;
				state_d = S_EXP;
				cnt_d   = '0;
			end
			S_EXP: begin
				cmd   = '{op: OP_EXPS, sel: cnt_q};
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == 4'd15) state_d = S_DWELL;
			end
			S_DWELL: begin
				cmd.op  = OP_DWELL;
				state_d = S_RD;
			end
			S_RD: state_d = S_CMP;
			S_CMP: begin
				if (stat.hit) begin
					cmd.op  = OP_CMP;
					state_d = S_RD;
				end else if (stat.done) begin
					state_d = S_OUT;
				end else begin
					state_d = S_MOVE;
				end
			end
			S_MOVE: begin
				cmd.op  = OP_MOVE;
				state_d = S_MOD;
				cnt_d   = 4'd8;
			end
			S_MOD: begin
				cmd   = '{op: OP_MOD, sel: cnt_q};
				cnt_d = cnt_q - 4'd1;
				if (cnt_q == 4'd0) state_d = S_WB;
			end
			S_WB: begin
				cmd.op  = OP_WB;
				state_d = S_OUT;
			end
			S_OUT: if (can_out) begin
				cmd.op  = OP_OUT;
				issue   = 1'b1;
				state_d = S_IDLE;
			end
			S_FIN: if (can_out) begin
				cmd.op  = OP_FIN;
				issue   = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			crd_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			crd_q   <= crd_d;
			if (issue) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== src/trap_model_walk_step_top.sv =====
// Step item: the work runs on the shared 32x32 multiplier (18 hash partial products,
// 16 squarings, 16 exp products), then the grid slots crossed are counted. A step
// with all slots recorded skips the walk and gives the final result.
// One item at a time; the next item is taken while a result waits in the output register.
// Reset (arst_n low): config to defaults, walker and time cleared; grid memory undefined.
`default_nettype none

module trap_model_walk_step_top import tmws_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [63:0]          cfg_data,
	tmws_in_if.sink              in_ch,
	tmws_out_if.source           out_ch
);

	cmd_t  cmd;
	stat_t stat;
	logic  in_ready;

	assign in_ch.ready = in_ready;

	tmws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tmws_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.in_take       (in_ch.valid & in_ready),
		.func          (in_ch.func),
		.grid_index    (in_ch.grid_index),
		.grid_time     (in_ch.grid_time),
		.rand_value    (in_ch.rand_value),
		.position_x    (out_ch.position_x),
		.position_y    (out_ch.position_y),
		.position_z    (out_ch.position_z),
		.first_index   (out_ch.first_index),
		.crossed_count (out_ch.crossed_count),
		.finished      (out_ch.finished)
	);

endmodule

`default_nettype wire

// ===== src/tmws_chk.sv =====
// Port-level checker for the walk engine, bound to the top level.
// Uses assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tmws_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] position_x,
	input logic [5:0]  first_index,
	input logic [6:0]  crossed_count
);

	`TMWS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`TMWS_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(position_x) && $stable(crossed_count))
	`TMWS_ASSERT_IMP(a_first_zero, clk, arst_n, out_valid && crossed_count == 7'd0, first_index == 6'd0)
	`TMWS_ASSERT_IMP(a_count_max, clk, arst_n, out_valid, crossed_count <= 7'd64)

endmodule

bind trap_model_walk_step_top tmws_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.position_x    (out_ch.position_x),
	.first_index   (out_ch.first_index),
	.crossed_count (out_ch.crossed_count)
);

`default_nettype wire
